// File: design/emac_pkg.sv
`timescale 1ns / 1ps

package emac_pkg;

  // Internal storage widths.
  localparam int ENERGY_BITS = 48;
  localparam int MINUTE_BITS = 24;

  // Field widths of the item and result channels and of the tariff.
  localparam int POWER_W      = 13;
  localparam int AVG_W        = 14;
  localparam int TARIFF_W     = 16;
  localparam int COST_W       = 30;
  localparam int ENERGY_OUT_W = 48;
  localparam int MINUTE_OUT_W = 24;

  // Seconds counter, divider and multiplier sizing.
  localparam int SEC_W     = 6;
  localparam int DIVISOR_W = MINUTE_BITS + 6;
  localparam int PROD_W    = AVG_W + TARIFF_W;

  // Constants of the measurement rules.
  localparam logic [SEC_W-1:0]    SEC_LAST     = SEC_W'(59);
  localparam logic [POWER_W-1:0]  MIN_RESET    = POWER_W'(6000);
  localparam logic [TARIFF_W-1:0] TARIFF_RESET = TARIFF_W'(194);
  localparam logic [AVG_W-1:0]    AVG_LIMIT    = {AVG_W{1'b1}};

  // Item function codes.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } emac_stat_t;

endpackage

// File: design/emac_in_if.sv
`timescale 1ns / 1ps

interface emac_in_if import emac_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [POWER_W-1:0] power_mw;

  modport source (output valid, func, power_mw, input ready);
  modport sink (input valid, func, power_mw, output ready);
endinterface

// File: design/emac_out_if.sv
`timescale 1ns / 1ps

interface emac_out_if import emac_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [POWER_W-1:0]      power_now_mw;
  logic [POWER_W-1:0]      power_max_mw;
  logic [POWER_W-1:0]      power_min_mw;
  logic [ENERGY_OUT_W-1:0] energy_mws;
  logic [MINUTE_OUT_W-1:0] elapsed_minutes;
  logic [AVG_W-1:0]        avg_power_mw;
  logic [COST_W-1:0]       cost_rate_micro;

  modport source (output valid, power_now_mw, power_max_mw, power_min_mw, energy_mws,
                  elapsed_minutes, avg_power_mw, cost_rate_micro, input ready);
  modport sink (input valid, power_now_mw, power_max_mw, power_min_mw, energy_mws,
                elapsed_minutes, avg_power_mw, cost_rate_micro, output ready);
endinterface

// File: design/emac_div.sv
`timescale 1ns / 1ps

// Restoring divider: one quotient bit per cycle, with the quotient clamped to the
// average field's range.
module emac_div import emac_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [ENERGY_BITS-1:0] dividend,
  input  logic [DIVISOR_W-1:0]   divisor,
  output emac_stat_t             stat,
  output logic [AVG_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(ENERGY_BITS);

  logic [ENERGY_BITS-1:0] dvd;
  logic [DIVISOR_W-1:0]   dsr;
  logic [DIVISOR_W-1:0]   rem;
  logic [AVG_W-1:0]       quo;
  logic                   ovf;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic                   done;

  logic [DIVISOR_W:0]     trial;
  logic [DIVISOR_W:0]     diff;
  logic                   fits;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial = {rem, dvd[ENERGY_BITS-1]};
    diff  = trial - {1'b0, dsr};
    fits  = (trial >= {1'b0, dsr});
  end

  // Control: counts one step per dividend bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ENERGY_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      dvd <= {dvd[ENERGY_BITS-2:0], 1'b0};
      rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo <= {quo[AVG_W-2:0], fits};
      ovf <= ovf | quo[AVG_W-1];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = ovf ? AVG_LIMIT : quo;

endmodule

// File: design/emac_mul.sv
`timescale 1ns / 1ps

// Shift-and-add multiplier: one multiplier bit per cycle.
module emac_mul import emac_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [AVG_W-1:0]    mcand_a,
  input  logic [TARIFF_W-1:0] mcand_b,
  output emac_stat_t          stat,
  output logic [PROD_W-1:0]   product
);

  localparam int CNT_W = $clog2(AVG_W);

  logic [AVG_W-1:0]  a_sh;
  logic [PROD_W-1:0] b_sh;
  logic [PROD_W-1:0] acc;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  // Control: one step per bit of the first operand.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(AVG_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial product accumulation.
  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= mcand_a;
      b_sh <= PROD_W'(mcand_b);
      acc  <= '0;
    end else if (busy) begin
      a_sh <= a_sh >> 1;
      b_sh <= b_sh << 1;
      if (a_sh[0]) begin
        acc <= acc + b_sh;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign product   = acc;

endmodule

// File: design/energy_meter_accumulator_top.sv
`timescale 1ns / 1ps
// Sequence: once a minute has passed, an accepted beat runs through the serial divider and then
// the serial multiplier before its result is valid; otherwise only through the multiplier.
// Flow: one item at a time; the next beat is taken as soon as the result is
// in the output register, which waits while the previous reading is not yet accepted.
// Reset: synchronous, active high; clears all measurements and sets the tariff to 194.
module energy_meter_accumulator_top import emac_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [TARIFF_W-1:0] cfg_wdata,
  emac_in_if.sink             in_ch,
  emac_out_if.source          out_ch
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LAUNCH = 6'b000010,
    ST_DIV    = 6'b000100,
    ST_MSTART = 6'b001000,
    ST_MUL    = 6'b010000,
    ST_PUSH   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [TARIFF_W-1:0]    tariff;
  logic [SEC_W-1:0]       second_count;
  logic [MINUTE_BITS-1:0] minute_count;
  logic [ENERGY_BITS-1:0] energy_total;
  logic [POWER_W-1:0]     max_power;
  logic [POWER_W-1:0]     min_power;
  logic [AVG_W-1:0]       avg_power;
  logic [POWER_W-1:0]     last_power;

  logic                   out_valid;
  logic                   in_beat;
  logic                   out_free;
  logic [ENERGY_BITS:0]   energy_sum;
  logic [DIVISOR_W-1:0]   divisor;

  logic                   div_start;
  emac_stat_t             div_stat;
  logic [AVG_W-1:0]       div_q;
  logic                   mul_start;
  emac_stat_t             mul_stat;
  logic [PROD_W-1:0]      mul_p;

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);

  // Saturating energy sum and divisor of sixty times the minute count.
  assign energy_sum = {1'b0, energy_total} + (ENERGY_BITS + 1)'(in_ch.power_mw);
  assign divisor    = DIVISOR_W'({minute_count, 6'b0}) - DIVISOR_W'({minute_count, 2'b0});

  assign div_start = (state == ST_LAUNCH) && (minute_count != '0);
  assign mul_start = ((state == ST_LAUNCH) && (minute_count == '0)) || (state == ST_MSTART);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) state_next = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        state_next = (minute_count != '0) ? ST_DIV : ST_MUL;
      end
      ST_DIV: begin
        if (div_stat.done) state_next = ST_MSTART;
      end
      ST_MSTART: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_stat.done) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Tariff register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tariff <= TARIFF_RESET;
    end else if (cfg_we) begin
      tariff <= cfg_wdata;
    end
  end

  // Measurement state, updated on each accepted beat and by the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      second_count <= '0;
      minute_count <= '0;
      energy_total <= '0;
      max_power    <= '0;
      min_power    <= MIN_RESET;
      avg_power    <= '0;
      last_power   <= '0;
    end else if (in_beat) begin
      if (in_ch.func == FUNC_CLEAR) begin
        second_count <= '0;
        minute_count <= '0;
        energy_total <= '0;
        max_power    <= '0;
        min_power    <= MIN_RESET;
        avg_power    <= '0;
        last_power   <= '0;
      end else begin
        if (second_count == SEC_LAST) begin
          second_count <= '0;
          if (minute_count != {MINUTE_BITS{1'b1}}) begin
            minute_count <= minute_count + 1'b1;
          end
        end else begin
          second_count <= second_count + 1'b1;
        end
        last_power   <= in_ch.power_mw;
        energy_total <= energy_sum[ENERGY_BITS] ? {ENERGY_BITS{1'b1}}
                                                : energy_sum[ENERGY_BITS-1:0];
        if (in_ch.power_mw > max_power) max_power <= in_ch.power_mw;
        if (in_ch.power_mw < min_power) min_power <= in_ch.power_mw;
      end
    end else if ((state == ST_DIV) && div_stat.done) begin
      avg_power <= div_q;
    end
  end

  emac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (energy_total),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  emac_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand_a (avg_power),
    .mcand_b (tariff),
    .stat    (mul_stat),
    .product (mul_p)
  );

  // Output register: holds a finished result until its beat completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_PUSH) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_PUSH) && out_free) begin
      out_ch.power_now_mw    <= last_power;
      out_ch.power_max_mw    <= max_power;
      out_ch.power_min_mw    <= min_power;
      out_ch.energy_mws      <= ENERGY_OUT_W'(energy_total);
      out_ch.elapsed_minutes <= MINUTE_OUT_W'(minute_count);
      out_ch.avg_power_mw    <= avg_power;
      out_ch.cost_rate_micro <= COST_W'(mul_p);
    end
  end

  assign out_ch.valid = out_valid;

endmodule

// File: test/tb_energy_meter_accumulator_top.sv
`timescale 1ns / 1ps

module tb_energy_meter_accumulator_top import emac_pkg::*; ();

  localparam int                     SECONDS_PER_MINUTE = 60;
  localparam logic [ENERGY_BITS-1:0] ENERGY_CEIL        = {ENERGY_BITS{1'b1}};
  localparam logic [MINUTE_BITS-1:0] MINUTE_CEIL        = {MINUTE_BITS{1'b1}};
  localparam int                     HOLD_CYCLES        = 400;
  localparam int                     SETTLE_CYCLES      = 8;
  localparam int                     TAIL_CYCLES        = 80;
  localparam int                     REPORT_LIMIT       = 10;

  // One meter input beat.
  typedef struct {
    logic               func;
    logic [POWER_W-1:0] power;
  } meter_cmd_t;

  // One meter reading as the result channel carries it.
  typedef struct {
    logic [POWER_W-1:0]      power_now;
    logic [POWER_W-1:0]      power_max;
    logic [POWER_W-1:0]      power_min;
    logic [ENERGY_OUT_W-1:0] energy;
    logic [MINUTE_OUT_W-1:0] minutes;
    logic [AVG_W-1:0]        avg_power;
    logic [COST_W-1:0]       cost_rate;
  } meter_reading_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [TARIFF_W-1:0] cfg_wdata;

  emac_in_if  in_ch ();
  emac_out_if out_ch ();

  energy_meter_accumulator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Meter state as the block should hold it.
  logic [TARIFF_W-1:0]    tariff_now;
  logic [SEC_W-1:0]       second_acc;
  logic [MINUTE_BITS-1:0] minute_acc;
  logic [ENERGY_BITS-1:0] energy_acc;
  logic [POWER_W-1:0]     peak_power;
  logic [POWER_W-1:0]     floor_power;
  logic [AVG_W-1:0]       mean_power;
  logic [POWER_W-1:0]     latest_power;

  meter_cmd_t     sample_queue[$];
  meter_reading_t reading_due[$];
  int             queued_total   = 0;
  int             accepted_total = 0;
  int             mismatches     = 0;
  int             send_gap_pct   = 0;
  int             recv_stall_pct = 0;
  logic           hold_off       = 1'b0;
  event           hold_trig;

  // Return the meter to its cleared measurements and time.
  task automatic clear_meter();
    second_acc   = '0;
    minute_acc   = '0;
    energy_acc   = '0;
    peak_power   = '0;
    floor_power  = MIN_RESET;
    mean_power   = '0;
    latest_power = '0;
  endtask

  // Apply one beat to the meter state and produce the reading it causes.
  task automatic advance_meter(input meter_cmd_t cmd, output meter_reading_t rd);
    logic [ENERGY_BITS:0] sum;
    logic [63:0]          quotient;
    if (cmd.func == FUNC_CLEAR) begin
      clear_meter();
    end else begin
      // The seconds count moves first and wraps into the minute count.
      if (second_acc == SEC_LAST) begin
        second_acc = '0;
        if (minute_acc != MINUTE_CEIL) minute_acc = minute_acc + 1'b1;
      end else begin
        second_acc = second_acc + 1'b1;
      end
      latest_power = cmd.power;
      sum = {1'b0, energy_acc} + (ENERGY_BITS + 1)'(cmd.power);
      energy_acc = (sum > {1'b0, ENERGY_CEIL}) ? ENERGY_CEIL : sum[ENERGY_BITS-1:0];
      if (cmd.power > peak_power) peak_power = cmd.power;
      if (cmd.power < floor_power) floor_power = cmd.power;
      // The average is only refreshed once a whole minute has gone by.
      if (minute_acc != '0) begin
        quotient = 64'(energy_acc) / (64'(minute_acc) * 64'(SECONDS_PER_MINUTE));
        mean_power = (quotient > 64'(AVG_LIMIT)) ? AVG_LIMIT : quotient[AVG_W-1:0];
      end
    end
    rd.power_now = latest_power;
    rd.power_max = peak_power;
    rd.power_min = floor_power;
    rd.energy    = ENERGY_OUT_W'(energy_acc);
    rd.minutes   = MINUTE_OUT_W'(minute_acc);
    rd.avg_power = mean_power;
    rd.cost_rate = COST_W'(64'(mean_power) * 64'(tariff_now));
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%s mismatch at %0t: expected %0d, got %0d", name, $realtime, want, got);
    end
  endtask

  task automatic queue_beat(input logic func, input logic [POWER_W-1:0] power);
    meter_cmd_t cmd;
    cmd.func  = func;
    cmd.power = power;
    sample_queue.push_back(cmd);
    queued_total++;
  endtask

  // Mostly ticks so that minutes build up; clears are rare.
  task automatic queue_random(input int count);
    logic               func;
    logic [POWER_W-1:0] power;
    int                 pick;
    repeat (count) begin
      func = ($urandom_range(999) < 6) ? FUNC_CLEAR : FUNC_TICK;
      pick = $urandom_range(99);
      if (pick < 75)      power = POWER_W'($urandom_range(5999));
      else if (pick < 82) power = $urandom_range(1) ? POWER_W'(5999) : '0;
      else if (pick < 92) power = POWER_W'($urandom_range(8191, 6000));
      else                power = POWER_W'($urandom());
      queue_beat(func, power);
    end
  endtask

  // Wait until every queued beat has been taken and every reading has come back.
  task automatic wait_drained();
    while (accepted_total != queued_total || reading_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tariff(input logic [TARIFF_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    tariff_now = value;
  endtask

  // Driver: present queued beats and update the expected readings on each accepted beat.
  always @(posedge clk) begin
    meter_cmd_t     taken;
    meter_cmd_t     next_cmd;
    meter_reading_t rd;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.func  = in_ch.func;
        taken.power = in_ch.power_mw;
        advance_meter(taken, rd);
        reading_due.push_back(rd);
        accepted_total++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_cmd = sample_queue.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.func     <= next_cmd.func;
          in_ch.power_mw <= next_cmd.power;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted reading with the oldest expected one.
  always @(posedge clk) begin
    meter_reading_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (reading_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected reading at %0t: energy %0d", $realtime, out_ch.energy_mws);
        end else begin
          want = reading_due.pop_front();
          check_field("power_now_mw", want.power_now, out_ch.power_now_mw);
          check_field("power_max_mw", want.power_max, out_ch.power_max_mw);
          check_field("power_min_mw", want.power_min, out_ch.power_min_mw);
          check_field("energy_mws", want.energy, out_ch.energy_mws);
          check_field("elapsed_minutes", want.minutes, out_ch.elapsed_minutes);
          check_field("avg_power_mw", want.avg_power, out_ch.avg_power_mw);
          check_field("cost_rate_micro", want.cost_rate, out_ch.cost_rate_micro);
        end
      end
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so that the block backs up and stalls its input.
  initial begin
    @(hold_trig);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus: directed beats, then random phases under different tariffs and idling.
  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_TICK;
    in_ch.power_mw = '0;
    out_ch.ready   = 1'b0;
    tariff_now     = TARIFF_RESET;
    clear_meter();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed beats under the reset tariff: clear on a fresh meter, field extremes,
    // samples above the nominal range, alternating bit patterns and repeated clears.
    queue_beat(FUNC_CLEAR, '0);
    queue_beat(FUNC_TICK, '0);
    queue_beat(FUNC_TICK, POWER_W'(5999));
    queue_beat(FUNC_TICK, POWER_W'(8191));
    queue_beat(FUNC_TICK, POWER_W'(6000));
    queue_beat(FUNC_TICK, POWER_W'(1));
    queue_beat(FUNC_TICK, POWER_W'(5998));
    queue_beat(FUNC_TICK, POWER_W'(4096));
    queue_beat(FUNC_TICK, POWER_W'(2730));
    queue_beat(FUNC_TICK, POWER_W'(5461));
    queue_beat(FUNC_CLEAR, '0);
    queue_beat(FUNC_TICK, POWER_W'(3000));
    queue_beat(FUNC_CLEAR, POWER_W'(8191));
    queue_beat(FUNC_CLEAR, '0);
    queue_beat(FUNC_TICK, '0);
    wait_drained();

    // Highest tariff, no idling, with a long receiver hold-off.
    write_tariff('1);
    queue_random(200);
    -> hold_trig;
    wait_drained();

    // Zero tariff with a mostly idle sender.
    write_tariff('0);
    send_gap_pct   = 63;
    recv_stall_pct = 0;
    queue_random(200);
    wait_drained();

    // Random tariff with a mostly stalled receiver.
    write_tariff(TARIFF_W'($urandom()));
    send_gap_pct   = 0;
    recv_stall_pct = 63;
    queue_random(250);
    wait_drained();

    // Random tariff with light idling on both sides.
    write_tariff(TARIFF_W'($urandom()));
    send_gap_pct   = 15;
    recv_stall_pct = 15;
    queue_random(280);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && reading_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
